/* sv/adrc_pkg.sv */
`timescale 1ns / 1ps

package adrc_pkg;

    localparam int unsigned DB_PER_OCTAVE_Q16 = 394566;
    localparam int unsigned OCTAVE_PER_DB_Q16 = 10885;
    localparam int unsigned FLOOR_DB          = 120;
    localparam int unsigned RED_MAX           = 32767;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_INV_RATIO = 3'd1;
    localparam logic [2:0] REG_MAKEUP    = 3'd2;
    localparam logic [2:0] REG_ATTACK    = 3'd3;
    localparam logic [2:0] REG_RELEASE   = 3'd4;

    // One-shot datapath commands issued by the controller.
    typedef struct packed {
        logic load;      // capture sample, find magnitude and exponent
        logic sq_step;   // one squaring step of the log2 fraction
        logic lvl_mul;   // level span times dB per octave
        logic lvl_fin;   // clamp level, difference to threshold
        logic rat_mul;   // difference times inverse ratio
        logic red_fin;   // raw reduction, choose alpha
        logic smo_mul0;  // alpha times previous reduction
        logic smo_mul1;  // (1 - alpha) times raw reduction
        logic smo_fin;   // new smoothed reduction, gain exponent product
        logic exp_fin;   // gain exponent, start of the 2^fraction product
        logic ex_step;   // one step of the 2^fraction product
        logic out_fin;   // final shift and saturation
    } t_cmd;

    typedef struct packed {
        logic sq_last;
        logic ex_last;
    } t_stat;

    function automatic logic [31:0] exp2_tab(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd0:    v = 32'd1518500250;
            4'd1:    v = 32'd1276901417;
            4'd2:    v = 32'd1170923762;
            4'd3:    v = 32'd1121280436;
            4'd4:    v = 32'd1097253708;
            4'd5:    v = 32'd1085434106;
            4'd6:    v = 32'd1079572136;
            4'd7:    v = 32'd1076653033;
            4'd8:    v = 32'd1075196443;
            4'd9:    v = 32'd1074468888;
            4'd10:   v = 32'd1074105294;
            4'd11:   v = 32'd1073923544;
            default: v = 32'd1073741824;
        endcase
        return v;
    endfunction

endpackage

/* sv/adrc_ctrl.sv */
`timescale 1ns / 1ps

module adrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output adrc_pkg::t_cmd   o_cmd,
    input  adrc_pkg::t_stat  i_stat
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SQ   = 13'b0000000000010,
        S_LMUL = 13'b0000000000100,
        S_LFIN = 13'b0000000001000,
        S_RMUL = 13'b0000000010000,
        S_RFIN = 13'b0000000100000,
        S_SM0  = 13'b0000001000000,
        S_SM1  = 13'b0000010000000,
        S_SFIN = 13'b0000100000000,
        S_EFIN = 13'b0001000000000,
        S_EX   = 13'b0010000000000,
        S_OFIN = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // The result register holds until taken, so the next item waits in S_OUT.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_stat.sq_last) n_state = S_LMUL;
            end
            S_LMUL: begin o_cmd.lvl_mul = 1'b1; n_state = S_LFIN; end
            S_LFIN: begin o_cmd.lvl_fin = 1'b1; n_state = S_RMUL; end
            S_RMUL: begin o_cmd.rat_mul = 1'b1; n_state = S_RFIN; end
            S_RFIN: begin o_cmd.red_fin = 1'b1; n_state = S_SM0; end
            S_SM0:  begin o_cmd.smo_mul0 = 1'b1; n_state = S_SM1; end
            S_SM1:  begin o_cmd.smo_mul1 = 1'b1; n_state = S_SFIN; end
            S_SFIN: begin o_cmd.smo_fin = 1'b1; n_state = S_EFIN; end
            S_EFIN: begin o_cmd.exp_fin = 1'b1; n_state = S_EX; end
            S_EX: begin
                o_cmd.ex_step = 1'b1;
                if (i_stat.ex_last) n_state = S_OFIN;
            end
            S_OFIN: begin o_cmd.out_fin = 1'b1; n_state = S_OUT; end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* sv/adrc_dp.sv */
`timescale 1ns / 1ps

module adrc_dp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DB_FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [15:0]             i_threshold_db,
    input  logic [16:0]             i_inv_ratio,
    input  logic [12:0]             i_makeup_gain_db,
    input  logic [15:0]             i_attack_coeff,
    input  logic [15:0]             i_release_coeff,
    input  adrc_pkg::t_cmd          i_cmd,
    output adrc_pkg::t_stat         o_stat,
    output logic [15:0]             o_gain_linear,
    output logic [14:0]             o_gain_reduction_db
);

    localparam int EW = $clog2(SAMPLE_WIDTH);
    localparam int FLOOR_V = adrc_pkg::FLOOR_DB * (1 << DB_FRAC_BITS);
    localparam int LSH = 32 - DB_FRAC_BITS;
    localparam int GSH = DB_FRAC_BITS + 4;

    // Magnitude and its exponent.
    logic [SAMPLE_WIDTH-1:0] w_mag;
    logic [EW-1:0]           w_e;
    always_comb begin
        w_mag = i_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_sample)
                                         : SAMPLE_WIDTH'(i_sample);
        w_e = '0;
        for (int b = 0; b < SAMPLE_WIDTH; b++)
            if (w_mag[b]) w_e = EW'(b);
    end

    logic              r_zero;
    logic [EW-1:0]     r_e;
    logic [31:0]       r_y;      // Q30 mantissa, below 2.0
    logic [3:0]        r_bit;    // current fraction bit
    logic [15:0]       r_frac;
    logic [63:0]       r_prod;
    logic signed [23:0] r_diff;  // level minus threshold
    logic              r_above;
    logic [15:0]       r_red;
    logic [15:0]       r_alpha;
    logic [15:0]       r_smooth;
    logic [47:0]       r_acc;
    logic signed [31:0] r_t;
    logic signed [19:0] r_n;
    logic [3:0]        r_k;
    logic [31:0]       r_m;
    logic [15:0]       r_gain;

    logic [63:0] w_sq;
    assign w_sq = 64'(r_y) * 64'(r_y);
    logic [33:0] w_ysq;
    assign w_ysq = w_sq[63:30];

    assign o_stat.sq_last = (r_bit == 4'd0);
    assign o_stat.ex_last = (r_k == 4'd11);

    // Span in Q16 octaves below full scale.
    logic [31:0] w_span;
    assign w_span = 32'((SAMPLE_WIDTH - 1) * 65536) - ((32'(r_e) << 16) | 32'(r_frac));

    logic [63:0] w_down;
    assign w_down = (r_prod + (64'd1 << (31 - DB_FRAC_BITS))) >> LSH;
    logic signed [23:0] w_level;
    assign w_level = (r_zero || w_down > 64'(FLOOR_V)) ? -24'(FLOOR_V)
                                                     : -$signed(24'(w_down));

    logic [16:0] w_inv;
    assign w_inv = (i_inv_ratio > 17'd65536) ? 17'd65536 : i_inv_ratio;

    logic [17:0] w_d;
    assign w_d = 18'(r_diff) - 18'(r_prod >> 16);
    logic [15:0] w_r;
    assign w_r = !r_above ? 16'd0 : (w_d > 18'(adrc_pkg::RED_MAX)) ? 16'(adrc_pkg::RED_MAX)
                                                                  : w_d[15:0];

    logic [15:0] w_y;
    assign w_y = 16'((r_acc + 48'(r_prod) + 48'd32768) >> 16);

    logic signed [17:0] w_v;
    assign w_v = $signed({5'd0, i_makeup_gain_db}) - $signed({2'b0, w_y});
    logic [17:0] w_vabs;
    assign w_vabs = w_v[17] ? 18'(-w_v) : 18'(w_v);

    logic [31:0] w_tabv;
    assign w_tabv = adrc_pkg::exp2_tab(r_k);
    logic [63:0] w_mm;
    assign w_mm = 64'(r_m) * 64'(w_tabv);

    logic [5:0]  w_s;
    logic [31:0] w_g;
    always_comb begin
        w_s = 6'(20'sd18 - r_n);
        w_g = (32'(r_m) + (32'd1 << (w_s - 6'd1))) >> w_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (w_mag == '0);
            r_e    <= w_e;
            r_y    <= 32'(64'(w_mag) << (30 - 32'(w_e)));
            r_bit  <= 4'd15;
            r_frac <= '0;
        end
        if (i_cmd.sq_step) begin
            if (w_ysq >= 34'(2) << 30) begin
                r_y <= 32'(w_ysq >> 1);
                r_frac[r_bit] <= 1'b1;
            end else begin
                r_y <= 32'(w_ysq);
            end
            r_bit <= r_bit - 4'd1;
        end
        if (i_cmd.lvl_mul)
            r_prod <= 64'(w_span) * 64'(adrc_pkg::DB_PER_OCTAVE_Q16);
        if (i_cmd.lvl_fin) begin
            r_diff  <= w_level - 24'($signed(i_threshold_db));
            r_above <= (w_level >= 24'($signed(i_threshold_db)));
        end
        if (i_cmd.rat_mul)
            r_prod <= 64'(r_diff[16:0]) * 64'(w_inv);
        if (i_cmd.red_fin) begin
            r_red   <= w_r;
            r_alpha <= (w_r > r_smooth) ? i_attack_coeff : i_release_coeff;
        end
        if (i_cmd.smo_mul0)
            r_acc <= 48'(r_alpha) * 48'(r_smooth);
        if (i_cmd.smo_mul1)
            r_prod <= 64'(17'd65536 - 17'(r_alpha)) * 64'(r_red);
        if (i_cmd.smo_fin) begin
            r_prod   <= 64'(w_vabs) * 64'(adrc_pkg::OCTAVE_PER_DB_Q16);
            r_above  <= w_v[17];
        end
        if (i_cmd.exp_fin) begin
            r_t <= r_above ? -32'((r_prod + 64'((1 << GSH) - 1)) >> GSH)
                           : 32'(r_prod >> GSH);
            r_k <= 4'd0;
            r_m <= 32'd1 << 30;
        end
        if (i_cmd.ex_step) begin
            if (r_k == 4'd0)
                r_n <= 20'(r_t >>> 12);
            if (r_t[4'd11 - r_k]) r_m <= 32'(w_mm >> 30);
            r_k <= r_k + 4'd1;
        end
        if (i_cmd.out_fin) begin
            if (r_n >= 20'sd4)      r_gain <= 16'hFFFF;
            else if (r_n < -20'sd22) r_gain <= 16'd0;
            else                    r_gain <= (w_g > 32'd65535) ? 16'hFFFF : w_g[15:0];
        end
        if (!i_rst_n)           r_smooth <= '0;
        else if (i_cmd.smo_fin) r_smooth <= w_y;
    end

    assign o_gain_linear       = r_gain;
    assign o_gain_reduction_db = r_smooth[14:0];

endmodule

/* sv/audio_dynamic_range_compressor.sv */
`timescale 1ns / 1ps
// Each item passes through 16 log squaring steps, 12 steps of the 2^x product,
// and nine multiply/finish states between item accept and result valid.
// A new item is taken only once the previous result has been taken.
// Reset (synchronous, active low) clears the controller, the smoothed reduction,
// and loads the register defaults (inv_ratio one, all others zero).

module audio_dynamic_range_compressor #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DB_FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [15:0]             o_gain_linear,
    output logic [14:0]             o_gain_reduction_db,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [16:0]             i_cfg_data
);

    logic [15:0] r_threshold_db;
    logic [16:0] r_inv_ratio;
    logic [12:0] r_makeup_gain_db;
    logic [15:0] r_attack_coeff;
    logic [15:0] r_release_coeff;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_db   <= '0;
            r_inv_ratio      <= 17'd65536;
            r_makeup_gain_db <= '0;
            r_attack_coeff   <= '0;
            r_release_coeff  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                adrc_pkg::REG_THRESHOLD: r_threshold_db   <= i_cfg_data[15:0];
                adrc_pkg::REG_INV_RATIO: r_inv_ratio      <= i_cfg_data;
                adrc_pkg::REG_MAKEUP:    r_makeup_gain_db <= i_cfg_data[12:0];
                adrc_pkg::REG_ATTACK:    r_attack_coeff   <= i_cfg_data[15:0];
                adrc_pkg::REG_RELEASE:   r_release_coeff  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    adrc_pkg::t_cmd  w_cmd;
    adrc_pkg::t_stat w_stat;

    // The controller sequences the log, smoothing and exponent steps.
    adrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // The datapath holds the multipliers and the smoothing state.
    adrc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DB_FRAC_BITS (DB_FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sample            (i_sample),
        .i_threshold_db      (r_threshold_db),
        .i_inv_ratio         (r_inv_ratio),
        .i_makeup_gain_db    (r_makeup_gain_db),
        .i_attack_coeff      (r_attack_coeff),
        .i_release_coeff     (r_release_coeff),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_gain_linear       (o_gain_linear),
        .o_gain_reduction_db (o_gain_reduction_db)
    );

endmodule
